/* src/fir_pkg.sv */
// fir_pkg: shared types and constants of the fir convolver
// controller command and status structs, state encoding, request codes
// no dependencies

package fir_pkg;

  localparam int CFG_W      = 7;
  localparam int COEF_IDX_W = 6;
  localparam int TAP_IDX_W  = 6;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                 coef_we;
    logic                 shift_in;
    logic                 shift_zero;
    logic                 clear_line;
    logic                 issue;
    logic                 issue_first;
    logic [TAP_IDX_W-1:0] issue_idx;
    logic                 load_out;
    logic                 last_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

/* src/fir_if.sv */
// fir_if: request and result channel interfaces of the fir convolver
// depends on fir_pkg for field widths

interface fir_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [fir_pkg::COEF_IDX_W-1:0]   coef_index;
  logic signed [SAMPLE_BITS-1:0]    value;
  logic                             last_sample;

  modport source (output valid, output req_type, output coef_index, output value,
                  output last_sample, input ready);
  modport sink   (input valid, input req_type, input coef_index, input value,
                  input last_sample, output ready);
endinterface

interface fir_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          last_out;
  logic                          saturated;

  modport source (output valid, output out_sample, output last_out, output saturated,
                  input ready);
  modport sink   (input valid, input out_sample, input last_out, input saturated,
                  output ready);
endinterface

/* src/fir_ctrl.sv */
// fir_ctrl: controller state machine of the fir convolver
// holds tap count, tap counter and tail count; drives fir_pkg::cmd_t
// depends on fir_pkg

module fir_ctrl #(
  parameter int MAX_TAPS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic                      in_last_sample,
  input  logic                      cfg_we,
  input  logic [fir_pkg::CFG_W-1:0] cfg_data,
  input  fir_pkg::status_t          status,
  output fir_pkg::cmd_t             cmd
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  fir_pkg::state_t           state_r, state_nxt;
  logic [fir_pkg::CFG_W-1:0] taps_raw_r;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [CNT_W-1:0]          tail_r, tail_nxt;
  logic                      last_r, last_nxt;
  logic [CNT_W-1:0]          taps_eff;

  always_comb begin
    if (taps_raw_r == '0) begin
      taps_eff = CNT_W'(1);
    end else if (taps_raw_r > fir_pkg::CFG_W'(MAX_TAPS)) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = taps_raw_r[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fir_pkg::ST_IDLE;
      taps_raw_r <= fir_pkg::CFG_W'(1);
      idx_r      <= '0;
      tail_r     <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      tail_r  <= tail_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        taps_raw_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tail_nxt  = tail_r;
    last_nxt  = last_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.issue_idx = fir_pkg::TAP_IDX_W'(idx_r);
    case (state_r)
      fir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == fir_pkg::REQ_COEF) begin
            cmd.coef_we = 1'b1;
          end else begin
            cmd.shift_in = 1'b1;
            last_nxt     = in_last_sample;
            tail_nxt     = in_last_sample ? taps_eff - CNT_W'(1) : '0;
            idx_nxt      = '0;
            state_nxt    = fir_pkg::ST_MAC;
          end
        end
      end
      fir_pkg::ST_MAC: begin
        cmd.issue       = 1'b1;
        cmd.issue_first = (idx_r == '0);
        if (idx_r == taps_eff - CNT_W'(1)) begin
          state_nxt = fir_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      fir_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = fir_pkg::ST_RESULT;
        end
      end
      fir_pkg::ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last_out = last_r && (tail_r == '0);
          if (tail_r != '0) begin
            cmd.shift_zero = 1'b1;
            tail_nxt       = tail_r - CNT_W'(1);
            idx_nxt        = '0;
            state_nxt      = fir_pkg::ST_MAC;
          end else begin
            cmd.clear_line = last_r;
            last_nxt       = 1'b0;
            state_nxt      = fir_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fir_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/fir_datapath.sv */
// fir_datapath: coefficient store, circular delay line, multiply-accumulate
// pipeline and output register with truncation and saturation
// depends on fir_pkg; driven by fir_ctrl

module fir_datapath #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fir_pkg::cmd_t                  cmd,
  output fir_pkg::status_t               status,
  input  logic [fir_pkg::COEF_IDX_W-1:0] in_coef_index,
  input  logic signed [SAMPLE_BITS-1:0]  in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_sample,
  output logic                           out_last_out,
  output logic                           out_saturated
);

  localparam int TAP_W = $clog2(MAX_TAPS);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W = PROD_W + TAP_W;
  localparam int SH = SAMPLE_BITS - 1;

  logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]    dly_vld_r;
  logic [TAP_W-1:0]       head_r;
  logic [TAP_W-1:0]       head_dec;
  logic [TAP_W:0]         addr_sum;
  logic [TAP_W-1:0]       rd_addr;
  logic [TAP_W-1:0]       coef_addr;

  logic signed [SAMPLE_BITS-1:0] dly_rd_r;
  logic signed [SAMPLE_BITS-1:0] coef_rd_r;
  logic                          rd_vld_r;
  logic                          a_v_r, a_first_r;
  logic                          b_v_r, b_first_r;
  logic signed [SAMPLE_BITS-1:0] a_smp;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       acc_r;

  logic signed [ACC_W-1:0]       bias;
  logic signed [ACC_W-1:0]       acc_biased;
  logic signed [ACC_W-1:0]       quot;
  logic                          fits;
  logic [SAMPLE_BITS-1:0]        res;

  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_last_r;
  logic                          out_sat_r;

  assign head_dec  = (head_r == '0) ? TAP_W'(MAX_TAPS - 1) : head_r - TAP_W'(1);
  assign addr_sum  = {1'b0, head_r} + {1'b0, cmd.issue_idx[TAP_W-1:0]};
  assign rd_addr   = (addr_sum >= (TAP_W + 1)'(MAX_TAPS)) ?
                     TAP_W'(addr_sum - (TAP_W + 1)'(MAX_TAPS)) : addr_sum[TAP_W-1:0];
  assign coef_addr = in_coef_index[TAP_W-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (cmd.coef_we &&
        ({1'b0, in_coef_index} < (fir_pkg::COEF_IDX_W + 1)'(MAX_TAPS))) begin
      coef_mem[coef_addr] <= in_value;
    end
    if (cmd.shift_in) begin
      dly_mem[head_dec] <= in_value;
    end
    dly_rd_r  <= dly_mem[rd_addr];
    coef_rd_r <= coef_mem[cmd.issue_idx[TAP_W-1:0]];
    rd_vld_r  <= dly_vld_r[rd_addr];
  end

  // delay line pointer and entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
      head_r    <= '0;
    end else begin
      if (cmd.clear_line) begin
        dly_vld_r <= '0;
      end else if (cmd.shift_in) begin
        dly_vld_r[head_dec] <= 1'b1;
      end else if (cmd.shift_zero) begin
        dly_vld_r[head_dec] <= 1'b0;
      end
      if (cmd.shift_in || cmd.shift_zero) begin
        head_r <= head_dec;
      end
    end
  end

  // mac pipeline
  assign a_smp    = rd_vld_r ? dly_rd_r : '0;
  assign prod_ext = {{TAP_W{prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      a_first_r <= 1'b0;
      b_v_r     <= 1'b0;
      b_first_r <= 1'b0;
    end else begin
      a_v_r     <= cmd.issue;
      a_first_r <= cmd.issue_first;
      b_v_r     <= a_v_r;
      b_first_r <= a_first_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_smp * coef_rd_r;
    if (b_v_r) begin
      acc_r <= b_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  assign status.pipe_busy = a_v_r | b_v_r;

  // truncate toward zero, then saturate
  assign bias       = acc_r[ACC_W-1] ? {{(ACC_W - SH){1'b0}}, {SH{1'b1}}} : '0;
  assign acc_biased = acc_r + bias;
  assign quot       = acc_biased >>> SH;
  assign fits       = (&quot[ACC_W-1:SH]) | ~(|quot[ACC_W-1:SH]);
  assign res        = fits ? quot[SAMPLE_BITS-1:0] :
                      {quot[ACC_W-1], {SH{~quot[ACC_W-1]}}};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= res;
      out_last_r   <= cmd.last_out;
      out_sat_r    <= ~fits;
    end
  end

  assign status.out_free = ~out_valid_r | out_ready;
  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_out    = out_last_r;
  assign out_saturated   = out_sat_r;

endmodule

/* src/fir_convolver.sv */
// fir_convolver: top level over fir_ctrl and fir_datapath, using fir_pkg and fir_if
// one multiply-accumulate per tap; once a sample is accepted (or a tail output loaded)
// ST_MAC issues each tap, ST_DRAIN empties the pipeline, ST_RESULT loads a free output
// register; a coefficient request is written on accept; a sample waits until the previous
// one is done (shared multiplier, tap loop); a last sample holds input for tap_count outputs
// reset (synchronous, rst_n low) clears the delay line, tail state and sets tap_count to 1

module fir_convolver #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  fir_in_if.sink                    in_ch,
  fir_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [fir_pkg::CFG_W-1:0] cfg_data
);

  fir_pkg::cmd_t    cmd;
  fir_pkg::status_t status;

  fir_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_req_type   (in_ch.req_type),
    .in_last_sample(in_ch.last_sample),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .status        (status),
    .cmd           (cmd)
  );

  fir_datapath #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_coef_index(in_ch.coef_index),
    .in_value     (in_ch.value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample   (out_ch.out_sample),
    .out_last_out (out_ch.last_out),
    .out_saturated(out_ch.saturated)
  );

endmodule
